[sv/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types, constants and the octant table of the midpoint circle
// rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

   localparam int COORD_BITS_DEF  = 12;
   localparam int ARC_BITS        = 11;
   localparam int ERR_BITS        = 14;
   localparam int PT_BITS         = 14;
   localparam int ADDR_BITS       = 32;
   localparam int COLOR_BITS      = 32;
   localparam int PITCH_BITS      = 16;
   localparam int BPP_BITS        = 3;
   localparam int DIM_BITS        = 13;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int IDX_BITS        = 3;
   localparam int POINTS_PER_STEP = 8;

   localparam logic [ADDR_BITS-1:0]  BASE_ADDRESS_RST    = '0;
   localparam logic [PITCH_BITS-1:0] ROW_PITCH_RST       = 16'd2048;
   localparam logic [BPP_BITS-1:0]   BYTES_PER_PIXEL_RST = 3'd4;
   localparam logic [COLOR_BITS-1:0] PIXEL_VALUE_RST     = '0;
   localparam logic [DIM_BITS-1:0]   SCREEN_WIDTH_RST    = 13'd512;
   localparam logic [DIM_BITS-1:0]   SCREEN_HEIGHT_RST   = 13'd512;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_STEP  = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BASE_ADDRESS    = 3'd0,
      CSR_ROW_PITCH       = 3'd1,
      CSR_BYTES_PER_PIXEL = 3'd2,
      CSR_PIXEL_VALUE     = 3'd3,
      CSR_SCREEN_WIDTH    = 3'd4,
      CSR_SCREEN_HEIGHT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  base_address;
      logic [PITCH_BITS-1:0] row_pitch;
      logic [BPP_BITS-1:0]   bytes_per_pixel;
      logic [COLOR_BITS-1:0] pixel_value;
      logic [DIM_BITS-1:0]   screen_width;
      logic [DIM_BITS-1:0]   screen_height;
   } cfg_type;

   typedef struct packed {
      logic [ARC_BITS-1:0] arc_x;
      logic [ARC_BITS-1:0] arc_y;
      logic                finished;
   } arc_step_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic swap;
      logic neg_x;
      logic neg_y;
   } octant_type;

   // point order: (+x,+y) (+y,+x) (-y,+x) (-x,+y) (-x,-y) (-y,-x) (+y,-x) (+x,-y)
   function automatic octant_type octant_of(input logic [IDX_BITS-1:0] idx);
      octant_type o;
      unique case (idx)
         3'd0: o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
         3'd1: o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
         3'd2: o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
         3'd3: o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
         3'd4: o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
         3'd5: o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
         3'd6: o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
         default: o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      endcase
      return o;
   endfunction

endpackage

[sv/mcr_queue.sv]
// ----------------------------------------------------------------------------
// mcr_queue
// Short FIFO of step descriptors between the front and the point pipeline.
// ----------------------------------------------------------------------------
module mcr_queue #(
   parameter int WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              pop_data,
   output mcr_pkg::queue_status_type     status
);

   localparam int PTR_BITS = $clog2(mcr_pkg::QUEUE_DEPTH);

   logic [WIDTH-1:0]  entry_ff [mcr_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == (PTR_BITS+1)'(mcr_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      pop_data = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/mcr_front.sv]
// ----------------------------------------------------------------------------
// mcr_front
// Accepts start and step transactions, runs the midpoint recurrence and
// queues one descriptor per step of an active circle.
// ----------------------------------------------------------------------------
module mcr_front #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [COORD_BITS-1:0]               center_x,
   input  logic [COORD_BITS-1:0]               center_y,
   input  logic [mcr_pkg::ARC_BITS-1:0]        radius,
   input  mcr_pkg::queue_status_type           q_status,
   output logic                                push,
   output logic [2*COORD_BITS+$bits(mcr_pkg::arc_step_type)-1:0] push_data
);

   localparam int AW = mcr_pkg::ARC_BITS + 2;
   localparam int EW = mcr_pkg::ERR_BITS + 2;

   logic [mcr_pkg::ARC_BITS-1:0] arc_x_ff, arc_x_in;
   logic [mcr_pkg::ARC_BITS-1:0] arc_y_ff, arc_y_in;
   logic [mcr_pkg::ERR_BITS-1:0] err_ff, err_in;
   logic [COORD_BITS-1:0]        origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]        origin_y_ff, origin_y_in;
   logic                         drawing_ff, drawing_in;

   logic                  accept;
   logic signed [AW-1:0]  x_cur, y_cur, x_nxt, y_nxt;
   logic signed [EW-1:0]  err0, err1, err2;
   logic                  drawing_nxt;
   mcr_pkg::arc_step_type step;

   always_comb begin
      req_ready = !q_status.full;
      accept    = req_valid && req_ready;

      x_cur = $signed({2'b00, arc_x_ff});
      y_cur = $signed({2'b00, arc_y_ff});
      err0  = $signed({{2{err_ff[mcr_pkg::ERR_BITS-1]}}, err_ff});
      y_nxt = y_cur;
      err1  = err0;
      if (err0[EW-1] || err0 == '0) begin
         y_nxt = y_cur + AW'(1);
         err1  = err0 + $signed({{2{y_nxt[AW-1]}}, y_nxt, 1'b1});
      end
      x_nxt = x_cur;
      err2  = err1;
      if (!err1[EW-1] && err1 != '0) begin
         x_nxt = x_cur - AW'(1);
         err2  = err1 - $signed({{2{x_nxt[AW-1]}}, x_nxt, 1'b1});
      end
      drawing_nxt = (x_nxt >= y_nxt);

      step.arc_x    = arc_x_ff;
      step.arc_y    = arc_y_ff;
      step.finished = !drawing_nxt;
      push_data     = {origin_y_ff, origin_x_ff, step};
      push          = 1'b0;

      arc_x_in    = arc_x_ff;
      arc_y_in    = arc_y_ff;
      err_in      = err_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      drawing_in  = drawing_ff;
      if (accept) begin
         if (req_mode == mcr_pkg::MODE_START) begin
            origin_x_in = center_x;
            origin_y_in = center_y;
            arc_x_in    = radius;
            arc_y_in    = '0;
            err_in      = '0;
            drawing_in  = 1'b1;
         end else if (drawing_ff) begin
            push       = 1'b1;
            arc_x_in   = x_nxt[mcr_pkg::ARC_BITS-1:0];
            arc_y_in   = y_nxt[mcr_pkg::ARC_BITS-1:0];
            err_in     = err2[mcr_pkg::ERR_BITS-1:0];
            drawing_in = drawing_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_x_ff    <= '0;
         arc_y_ff    <= '0;
         err_ff      <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         drawing_ff  <= 1'b0;
      end else begin
         arc_x_ff    <= arc_x_in;
         arc_y_ff    <= arc_y_in;
         err_ff      <= err_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         drawing_ff  <= drawing_in;
      end
   end

endmodule

[sv/mcr_back.sv]
// ----------------------------------------------------------------------------
// mcr_back
// Point pipeline: expands a step descriptor into eight mirrored points,
// one per cycle while the output is not stalled, and computes address and off-screen flag.
// ----------------------------------------------------------------------------
module mcr_back #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mcr_pkg::cfg_type                      cfg,
   input  logic                                  q_valid,
   input  logic [2*COORD_BITS+$bits(mcr_pkg::arc_step_type)-1:0] q_data,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mcr_pkg::PT_BITS-1:0]           point_x,
   output logic [mcr_pkg::PT_BITS-1:0]           point_y,
   output logic [mcr_pkg::ADDR_BITS-1:0]         byte_address,
   output logic [mcr_pkg::COLOR_BITS-1:0]        color,
   output logic                                  off_screen,
   output logic                                  last,
   output logic                                  finished
);

   localparam int SW  = ((COORD_BITS > mcr_pkg::PT_BITS) ? COORD_BITS : mcr_pkg::PT_BITS) + 2;
   localparam int STW = $bits(mcr_pkg::arc_step_type);
   localparam int PT  = mcr_pkg::PT_BITS;
   localparam logic [mcr_pkg::IDX_BITS-1:0] LAST_IDX =
      mcr_pkg::IDX_BITS'(mcr_pkg::POINTS_PER_STEP - 1);

   logic [mcr_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [PT-1:0]         s1_px_ff, s1_px_in;
   logic signed [PT-1:0]         s1_py_ff, s1_py_in;
   logic                         s1_last_ff, s1_last_in;
   logic                         s1_fin_ff, s1_fin_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic [PT-1:0]                s2_px_ff, s2_px_in;
   logic [PT-1:0]                s2_py_ff, s2_py_in;
   logic [mcr_pkg::ADDR_BITS-1:0] s2_row_ff, s2_row_in;
   logic [mcr_pkg::ADDR_BITS-1:0] s2_col_ff, s2_col_in;
   logic                         s2_off_ff, s2_off_in;
   logic                         s2_last_ff, s2_last_in;
   logic                         s2_fin_ff, s2_fin_in;
   logic                         out_valid_ff, out_valid_in;
   logic [PT-1:0]                out_px_ff, out_px_in;
   logic [PT-1:0]                out_py_ff, out_py_in;
   logic [mcr_pkg::ADDR_BITS-1:0] out_addr_ff, out_addr_in;
   logic [mcr_pkg::COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                         out_off_ff, out_off_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_fin_ff, out_fin_in;

   logic                         adv, load;
   mcr_pkg::arc_step_type        step;
   logic [COORD_BITS-1:0]        org_x, org_y;
   mcr_pkg::octant_type          oct;
   logic [SW-1:0]                off_a, off_b, base_x, base_y, sum_x, sum_y;
   logic signed [PT+mcr_pkg::PITCH_BITS:0] prod_y;
   logic signed [PT+mcr_pkg::BPP_BITS:0]   prod_x;

   always_comb begin
      adv  = !out_valid_ff || rsp_ready;
      load = adv && q_valid;
      pop  = load && (idx_ff == LAST_IDX);

      step  = q_data[STW-1:0];
      org_x = q_data[STW +: COORD_BITS];
      org_y = q_data[STW+COORD_BITS +: COORD_BITS];
      oct   = mcr_pkg::octant_of(idx_ff);

      off_a  = {{(SW-mcr_pkg::ARC_BITS){1'b0}}, oct.swap ? step.arc_y : step.arc_x};
      off_b  = {{(SW-mcr_pkg::ARC_BITS){1'b0}}, oct.swap ? step.arc_x : step.arc_y};
      base_x = {{(SW-COORD_BITS){1'b0}}, org_x};
      base_y = {{(SW-COORD_BITS){1'b0}}, org_y};
      sum_x  = oct.neg_x ? base_x - off_a : base_x + off_a;
      sum_y  = oct.neg_y ? base_y - off_b : base_y + off_b;

      idx_in      = load ? idx_ff + 1'b1 : idx_ff;
      s1_valid_in = adv ? q_valid : s1_valid_ff;
      s1_px_in    = load ? $signed(sum_x[PT-1:0]) : s1_px_ff;
      s1_py_in    = load ? $signed(sum_y[PT-1:0]) : s1_py_ff;
      s1_last_in  = load ? (idx_ff == LAST_IDX) : s1_last_ff;
      s1_fin_in   = load ? ((idx_ff == LAST_IDX) && step.finished) : s1_fin_ff;

      prod_y = s1_py_ff * $signed({1'b0, cfg.row_pitch});
      prod_x = s1_px_ff * $signed({1'b0, cfg.bytes_per_pixel});

      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s2_px_in    = adv ? s1_px_ff : s2_px_ff;
      s2_py_in    = adv ? s1_py_ff : s2_py_ff;
      s2_row_in   = adv ? mcr_pkg::ADDR_BITS'(prod_y) : s2_row_ff;
      s2_col_in   = adv ? mcr_pkg::ADDR_BITS'(prod_x) : s2_col_ff;
      s2_off_in   = adv ? (s1_px_ff[PT-1] || s1_py_ff[PT-1]
                           || (s1_px_ff[mcr_pkg::DIM_BITS-1:0] >= cfg.screen_width)
                           || (s1_py_ff[mcr_pkg::DIM_BITS-1:0] >= cfg.screen_height))
                        : s2_off_ff;
      s2_last_in  = adv ? s1_last_ff : s2_last_ff;
      s2_fin_in   = adv ? s1_fin_ff : s2_fin_ff;

      out_valid_in = adv ? s2_valid_ff : out_valid_ff;
      out_px_in    = adv ? s2_px_ff : out_px_ff;
      out_py_in    = adv ? s2_py_ff : out_py_ff;
      out_addr_in  = adv ? cfg.base_address + s2_row_ff + s2_col_ff : out_addr_ff;
      out_color_in = adv ? cfg.pixel_value : out_color_ff;
      out_off_in   = adv ? s2_off_ff : out_off_ff;
      out_last_in  = adv ? s2_last_ff : out_last_ff;
      out_fin_in   = adv ? s2_fin_ff : out_fin_ff;

      rsp_valid    = out_valid_ff;
      point_x      = out_px_ff;
      point_y      = out_py_ff;
      byte_address = out_addr_ff;
      color        = out_color_ff;
      off_screen   = out_off_ff;
      last         = out_last_ff;
      finished     = out_fin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff     <= s1_px_in;
      s1_py_ff     <= s1_py_in;
      s1_last_ff   <= s1_last_in;
      s1_fin_ff    <= s1_fin_in;
      s2_px_ff     <= s2_px_in;
      s2_py_ff     <= s2_py_in;
      s2_row_ff    <= s2_row_in;
      s2_col_ff    <= s2_col_in;
      s2_off_ff    <= s2_off_in;
      s2_last_ff   <= s2_last_in;
      s2_fin_ff    <= s2_fin_in;
      out_px_ff    <= out_px_in;
      out_py_ff    <= out_py_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_off_ff   <= out_off_in;
      out_last_ff  <= out_last_in;
      out_fin_ff   <= out_fin_in;
   end

endmodule

[sv/midpoint_circle_rasterizer.sv]
// Points leave one per cycle from the single point pipeline while a step is queued
//   and the output is not stalled; a start or a step with no active circle queues no descriptor.
// Requests are taken while the 2-entry descriptor queue has room.
// Reset: synchronous; clears the arc state and loads the register reset values.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle generator emitting eight mirrored points per step with
// frame-buffer address, color and off-screen flag.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // center_x, center_y, radius, zero fill
   input  logic [((2*COORD_BITS+mcr_pkg::ARC_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // point_x, point_y, byte_address, color, zero fill
   output logic [95:0]                            rsp_tdata,
   // off_screen, finished
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tlast,
   input  logic                                   csr_wr_en,
   input  logic [mcr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mcr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int QW = 2*COORD_BITS + $bits(mcr_pkg::arc_step_type);

   mcr_pkg::cfg_type          cfg_ff, cfg_in;
   mcr_pkg::queue_status_type q_status;
   logic                      push, pop;
   logic [QW-1:0]             push_data, pop_data;
   logic [mcr_pkg::PT_BITS-1:0]    point_x, point_y;
   logic [mcr_pkg::ADDR_BITS-1:0]  byte_address;
   logic [mcr_pkg::COLOR_BITS-1:0] color;
   logic                      off_screen, finished;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mcr_pkg::CSR_BASE_ADDRESS:    cfg_in.base_address = csr_wdata;
            mcr_pkg::CSR_ROW_PITCH:
               cfg_in.row_pitch = csr_wdata[mcr_pkg::PITCH_BITS-1:0];
            mcr_pkg::CSR_BYTES_PER_PIXEL:
               cfg_in.bytes_per_pixel = csr_wdata[mcr_pkg::BPP_BITS-1:0];
            mcr_pkg::CSR_PIXEL_VALUE:     cfg_in.pixel_value = csr_wdata;
            mcr_pkg::CSR_SCREEN_WIDTH:
               cfg_in.screen_width = csr_wdata[mcr_pkg::DIM_BITS-1:0];
            mcr_pkg::CSR_SCREEN_HEIGHT:
               cfg_in.screen_height = csr_wdata[mcr_pkg::DIM_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address    <= mcr_pkg::BASE_ADDRESS_RST;
         cfg_ff.row_pitch       <= mcr_pkg::ROW_PITCH_RST;
         cfg_ff.bytes_per_pixel <= mcr_pkg::BYTES_PER_PIXEL_RST;
         cfg_ff.pixel_value     <= mcr_pkg::PIXEL_VALUE_RST;
         cfg_ff.screen_width    <= mcr_pkg::SCREEN_WIDTH_RST;
         cfg_ff.screen_height   <= mcr_pkg::SCREEN_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .center_x  (req_tdata[COORD_BITS-1:0]),
      .center_y  (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .radius    (req_tdata[2*COORD_BITS +: mcr_pkg::ARC_BITS]),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   mcr_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   mcr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (!q_status.empty),
      .q_data       (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .point_x      (point_x),
      .point_y      (point_y),
      .byte_address (byte_address),
      .color        (color),
      .off_screen   (off_screen),
      .last         (rsp_tlast),
      .finished     (finished)
   );

   assign rsp_tdata = {4'b0000, color, byte_address, point_y, point_x};
   assign rsp_tuser = {finished, off_screen};

   a_fin_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && finished |-> rsp_tlast)
      else $error("finished flag on a point that is not the last of its step");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("descriptor pushed into a full queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule
